FILE: rtl/csl_pkg.sv
package csl_pkg;

    // default widths of the offset and line counters
    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int LINE_WIDTH_DEF   = 16;

    // token kinds
    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_INT    = 5'd2;
    localparam logic [4:0] KIND_DOUBLE = 5'd3;
    localparam logic [4:0] KIND_STRING = 5'd4;
    localparam logic [4:0] KIND_KW0    = 5'd5;
    localparam logic [4:0] KIND_OP0    = 5'd12;
    localparam logic [4:0] KIND_CHAR   = 5'd20;
    localparam logic [4:0] KIND_UNTERM = 5'd21;

    // characters with a role in the scanner
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_POINT  = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_IDENT     = 4'd1,
        MODE_NUMBER    = 4'd2,
        MODE_STRING    = 4'd3,
        MODE_OPWAIT    = 4'd4,
        MODE_SLASH     = 4'd5,
        MODE_LINECOM   = 4'd6,
        MODE_BLOCK     = 4'd7,
        MODE_BLOCKSTAR = 4'd8
    } csl_mode_t;

    // keywords, first character in the lowest byte
    localparam int KW_COUNT = 7;
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'h00_0000_6669,   // if
        40'h00_6573_6c65,   // else
        40'h65_6c69_6877,   // while
        40'h00_0000_6f64,   // do
        40'h00_0072_6f66,   // for
        40'h6b_6165_7262,   // break
        40'h00_0074_6e69    // int
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd5, 3'd2, 3'd3, 3'd5, 3'd3
    };

    // first characters of the two-character operators
    localparam int OP_COUNT = 8;
    localparam logic [7:0] OP_FIRST [OP_COUNT] = '{
        8'h3e, 8'h3c, 8'h3d, 8'h21, 8'h26, 8'h7c, 8'h2b, 8'h2d
    };
    localparam logic [3:0] OP_NONE = 4'd8;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // slot of an operator start character, OP_NONE if it is none
    function automatic logic [3:0] op_slot(input logic [7:0] c);
        logic [3:0] slot;
        slot = OP_NONE;
        for (int k = OP_COUNT - 1; k >= 0; k--) begin
            if (OP_FIRST[k] == c) begin
                slot = 4'(k);
            end
        end
        return slot;
    endfunction

endpackage

FILE: rtl/c_subset_lexer_top.sv
// output: a token enters the output queue as the byte that completes it is taken
// throughput: one source byte per cycle while s_axis_tready is high; a byte that
// completes two tokens needs two output transfers, so the rate is set by the
// one-token-per-cycle output port; a four-entry output queue parts the two sides;
// s_axis_tready drops when fewer than two entries are free
// reset: synchronous active-low aresetn; first_line returns to 1, scanner idles
module c_subset_lexer_top #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = csl_pkg::LINE_WIDTH_DEF,
    localparam int RES_BITS    = 13 + LINE_WIDTH + 2 * OFFSET_WIDTH,
    localparam int TDATA_W     = ((RES_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // source_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // token_kind, char_code, line_number, start_offset, text_length, zero fill
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast    // last_of_run
);

    localparam int DEPTH = 4;

    logic [15:0]         first_line_reg;
    logic                step_en;
    logic [1:0]          res_cnt;
    logic [RES_BITS-1:0] res0, res1;

    logic [RES_BITS:0]   q_mem [DEPTH];
    logic [1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [2:0]          cnt_reg, cnt_next;
    logic                pop;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_line_reg <= 16'd1;
        end else if (cfg_we) begin
            first_line_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready = (cnt_reg <= 3'(DEPTH - 2));
    assign step_en       = s_axis_tvalid && s_axis_tready;

    csl_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH),
        .LINE_WIDTH  (LINE_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .step_byte (s_axis_tdata),
        .first_line(first_line_reg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    // output queue storage
    always_ff @(posedge aclk) begin
        if (step_en && res_cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= {res_cnt == 2'd1, res0};
            if (res_cnt == 2'd2) begin
                q_mem[wr_ptr_reg + 2'd1] <= {1'b1, res1};
            end
        end
    end

    assign pop      = m_axis_tvalid && m_axis_tready;
    assign cnt_next = cnt_reg + (step_en ? {1'b0, res_cnt} : 3'd0) - {2'b0, pop};

    // output queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end else begin
            if (step_en) begin
                wr_ptr_reg <= wr_ptr_reg + res_cnt;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = TDATA_W'(q_mem[rd_ptr_reg][RES_BITS-1:0]);
    assign m_axis_tlast  = q_mem[rd_ptr_reg][RES_BITS];

endmodule

FILE: rtl/csl_core.sv
module csl_core #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = csl_pkg::LINE_WIDTH_DEF,
    localparam int RES_BITS    = 13 + LINE_WIDTH + 2 * OFFSET_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          step_byte,
    input  logic [15:0]         first_line,
    output logic [1:0]          res_cnt,
    output logic [RES_BITS-1:0] res0,
    output logic [RES_BITS-1:0] res1
);

    localparam logic [31:0] LINE_TOP32 = (LINE_WIDTH >= 32) ? 32'hffff_ffff
                                         : 32'((64'd1 << LINE_WIDTH) - 64'd1);

    csl_pkg::csl_mode_t      mode_reg, mode_next;
    logic [7:0]              held_reg, held_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next;
    logic [OFFSET_WIDTH-1:0] begin_reg, begin_next;
    logic [OFFSET_WIDTH-1:0] len_reg, len_next;
    logic                    point_reg, point_next;
    logic [39:0]             kwin_reg, kwin_next;

    logic [LINE_WIDTH-1:0]   line_load;
    logic [4:0]              word_kind;
    logic [3:0]              held_slot;
    logic                    done;
    logic                    restarted;

    // token from the current mode and token from a fresh byte
    logic                    a_v, b_v;
    logic [4:0]              a_kind, b_kind;
    logic [7:0]              a_char, b_char;
    logic [OFFSET_WIDTH-1:0] a_start, b_start;
    logic [OFFSET_WIDTH-1:0] a_len, b_len;

    function automatic logic [OFFSET_WIDTH-1:0] off_inc(input logic [OFFSET_WIDTH-1:0] v);
        return (v == '1) ? v : v + OFFSET_WIDTH'(1);
    endfunction

    function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
        return (v == '1) ? v : v + LINE_WIDTH'(1);
    endfunction

    // line number loaded at restart, clipped to the counter range
    assign line_load = ({16'b0, first_line} > LINE_TOP32) ? '1
                       : LINE_WIDTH'({16'b0, first_line});

    // keyword lookup on the gathered window
    always_comb begin
        word_kind = csl_pkg::KIND_IDENT;
        for (int k = 0; k < csl_pkg::KW_COUNT; k++) begin
            if (word_kind == csl_pkg::KIND_IDENT
                && len_reg == OFFSET_WIDTH'(csl_pkg::KW_LEN[k])
                && kwin_reg == csl_pkg::KW_TEXT[k]) begin
                word_kind = csl_pkg::KIND_KW0 + 5'(k);
            end
        end
    end

    assign held_slot = csl_pkg::op_slot(held_reg);

    // one scanner step
    always_comb begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        line_next  = line_reg;
        off_next   = off_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        point_next = point_reg;
        kwin_next  = kwin_reg;
        done       = 1'b1;
        restarted  = 1'b0;
        a_v = 1'b0; a_kind = csl_pkg::KIND_EOF; a_char = 8'd0;
        a_start = begin_reg; a_len = len_reg;
        b_v = 1'b0; b_kind = csl_pkg::KIND_EOF; b_char = 8'd0;
        b_start = off_reg; b_len = '0;

        // continue the token in progress
        case (mode_reg)
            csl_pkg::MODE_IDENT: begin
                if (csl_pkg::is_letter(step_byte) || csl_pkg::is_digit(step_byte)) begin
                    if (len_reg < OFFSET_WIDTH'(5)) begin
                        kwin_next = kwin_reg | ({32'b0, step_byte} << {len_reg[2:0], 3'b000});
                    end
                    len_next = off_inc(len_reg);
                end else begin
                    a_v = 1'b1; a_kind = word_kind;
                    done = 1'b0;
                end
            end
            csl_pkg::MODE_NUMBER: begin
                if (csl_pkg::is_digit(step_byte) || step_byte == csl_pkg::CH_POINT) begin
                    if (step_byte == csl_pkg::CH_POINT) begin
                        point_next = 1'b1;
                    end
                    len_next = off_inc(len_reg);
                end else begin
                    a_v = 1'b1;
                    a_kind = point_reg ? csl_pkg::KIND_DOUBLE : csl_pkg::KIND_INT;
                    done = 1'b0;
                end
            end
            csl_pkg::MODE_STRING: begin
                if (step_byte == csl_pkg::CH_QUOTE) begin
                    a_v = 1'b1; a_kind = csl_pkg::KIND_STRING;
                    mode_next = csl_pkg::MODE_IDLE;
                end else if (step_byte == csl_pkg::CH_NUL) begin
                    a_v = 1'b1; a_kind = csl_pkg::KIND_UNTERM;
                    done = 1'b0;
                end else begin
                    if (step_byte == csl_pkg::CH_NL) begin
                        line_next = line_inc(line_reg);
                    end
                    len_next = off_inc(len_reg);
                end
            end
            csl_pkg::MODE_OPWAIT: begin
                if (held_slot != csl_pkg::OP_NONE
                    && ((held_slot < 4'd4) ? (step_byte == csl_pkg::CH_EQ)
                                           : (step_byte == held_reg))) begin
                    a_v = 1'b1; a_kind = csl_pkg::KIND_OP0 + {1'b0, held_slot};
                    a_len = OFFSET_WIDTH'(2);
                    mode_next = csl_pkg::MODE_IDLE;
                end else begin
                    a_v = 1'b1; a_kind = csl_pkg::KIND_CHAR; a_char = held_reg;
                    a_len = OFFSET_WIDTH'(1);
                    done = 1'b0;
                end
            end
            csl_pkg::MODE_SLASH: begin
                if (step_byte == csl_pkg::CH_SLASH) begin
                    mode_next = csl_pkg::MODE_LINECOM;
                end else if (step_byte == csl_pkg::CH_STAR) begin
                    mode_next = csl_pkg::MODE_BLOCK;
                end else begin
                    a_v = 1'b1; a_kind = csl_pkg::KIND_CHAR; a_char = csl_pkg::CH_SLASH;
                    a_len = OFFSET_WIDTH'(1);
                    done = 1'b0;
                end
            end
            csl_pkg::MODE_LINECOM: begin
                if (step_byte == csl_pkg::CH_NL) begin
                    line_next = line_inc(line_reg);
                    mode_next = csl_pkg::MODE_IDLE;
                end else if (step_byte == csl_pkg::CH_NUL) begin
                    done = 1'b0;
                end
            end
            csl_pkg::MODE_BLOCK, csl_pkg::MODE_BLOCKSTAR: begin
                if (step_byte == csl_pkg::CH_NUL) begin
                    done = 1'b0;
                end else if (step_byte == csl_pkg::CH_NL) begin
                    line_next = line_inc(line_reg);
                    mode_next = csl_pkg::MODE_BLOCK;
                end else if (step_byte == csl_pkg::CH_STAR) begin
                    mode_next = csl_pkg::MODE_BLOCKSTAR;
                end else if (step_byte == csl_pkg::CH_SLASH
                             && mode_reg == csl_pkg::MODE_BLOCKSTAR) begin
                    mode_next = csl_pkg::MODE_IDLE;
                end else begin
                    mode_next = csl_pkg::MODE_BLOCK;
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase

        // byte handled as the start of something new
        if (!done) begin
            mode_next = csl_pkg::MODE_IDLE;
            if (step_byte == csl_pkg::CH_SPACE) begin
                mode_next = csl_pkg::MODE_IDLE;
            end else if (step_byte == csl_pkg::CH_NL) begin
                line_next = line_inc(line_next);
            end else if (csl_pkg::is_letter(step_byte)) begin
                mode_next  = csl_pkg::MODE_IDENT;
                begin_next = off_reg;
                len_next   = OFFSET_WIDTH'(1);
                kwin_next  = {32'b0, step_byte};
            end else if (csl_pkg::is_digit(step_byte)) begin
                mode_next  = csl_pkg::MODE_NUMBER;
                begin_next = off_reg;
                len_next   = OFFSET_WIDTH'(1);
                point_next = 1'b0;
            end else if (step_byte == csl_pkg::CH_QUOTE) begin
                mode_next  = csl_pkg::MODE_STRING;
                begin_next = off_inc(off_reg);
                len_next   = '0;
            end else if (step_byte == csl_pkg::CH_NUL) begin
                b_v = 1'b1; b_kind = csl_pkg::KIND_EOF;
                restarted  = 1'b1;
                held_next  = 8'd0;
                line_next  = line_load;
                begin_next = '0;
                len_next   = '0;
                point_next = 1'b0;
                kwin_next  = '0;
            end else if (csl_pkg::op_slot(step_byte) != csl_pkg::OP_NONE) begin
                mode_next  = csl_pkg::MODE_OPWAIT;
                held_next  = step_byte;
                begin_next = off_reg;
            end else if (step_byte == csl_pkg::CH_SLASH) begin
                mode_next  = csl_pkg::MODE_SLASH;
                begin_next = off_reg;
            end else begin
                b_v = 1'b1; b_kind = csl_pkg::KIND_CHAR; b_char = step_byte;
                b_len = OFFSET_WIDTH'(1);
            end
        end

        off_next = restarted ? '0 : off_inc(off_reg);
    end

    // result slots: the pending token goes first
    always_comb begin
        res_cnt = {1'b0, a_v} + {1'b0, b_v};
        res0 = a_v ? {a_len, a_start, line_reg, a_char, a_kind}
                   : {b_len, b_start, line_reg, b_char, b_kind};
        res1 = {b_len, b_start, line_reg, b_char, b_kind};
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= csl_pkg::MODE_IDLE;
            held_reg  <= 8'd0;
            line_reg  <= LINE_WIDTH'(1);
            off_reg   <= '0;
            begin_reg <= '0;
            len_reg   <= '0;
            point_reg <= 1'b0;
            kwin_reg  <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            line_reg  <= line_next;
            off_reg   <= off_next;
            begin_reg <= begin_next;
            len_reg   <= len_next;
            point_reg <= point_next;
            kwin_reg  <= kwin_next;
        end
    end

endmodule

FILE: verif/c_subset_lexer_top_tb.sv
`timescale 1ns / 100ps

module c_subset_lexer_top_tb;

    // one token record as it leaves the block
    typedef struct {
        logic [4:0]  kind;
        logic [7:0]  code;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // source_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // token_kind, char_code, line_number, start_offset, text_length, zero fill
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;            // last_of_run

    c_subset_lexer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // character tables
    string keyword_list [7] = '{"if", "else", "while", "do", "for", "break", "int"};
    string op_heads = "><=!&|+-";
    string op_tails = "====&|+-";
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punct_chars = "(){}[];,*%/?:.~^#";

    // scanner state as predicted
    csl_pkg::csl_mode_t lex_mode;
    logic [7:0]  held_op;
    logic [15:0] line_cnt;
    logic [15:0] src_offset;
    logic [15:0] tok_begin;
    logic [15:0] tok_len;
    logic        point_seen;
    logic [39:0] word_window;
    logic [15:0] first_line_cfg;

    token_t      step_tokens[$];
    token_t      pending_tokens[$];
    logic [7:0]  script[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function automatic bit alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == csl_pkg::CH_UNDER;
    endfunction

    function automatic bit numeral_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // operator slot of a character, 8 when it starts no operator
    function automatic int op_index(input logic [7:0] c);
        for (int k = 0; k < 8; k++) begin
            if (op_heads[k] == c) begin
                return k;
            end
        end
        return 8;
    endfunction

    // keyword kind of the gathered word, ident when none matches
    function automatic logic [4:0] word_kind();
        logic [39:0] w;
        logic [4:0]  kind;
        kind = csl_pkg::KIND_IDENT;
        for (int k = 0; k < 7; k++) begin
            w = '0;
            for (int i = 0; i < keyword_list[k].len(); i++) begin
                w[8*i +: 8] = keyword_list[k][i];
            end
            if (tok_len == 16'(keyword_list[k].len()) && word_window == w) begin
                kind = csl_pkg::KIND_KW0 + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic void emit(input logic [4:0] kind, input logic [7:0] code,
                                 input logic [15:0] start, input logic [15:0] len);
        token_t t;
        t.kind  = kind;
        t.code  = code;
        t.line  = line_cnt;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        if (step_tokens.size() < 2) begin
            step_tokens.insert(step_tokens.size(), t);
        end
    endfunction

    function automatic void restart_scan();
        lex_mode    = csl_pkg::MODE_IDLE;
        held_op     = 8'd0;
        line_cnt    = first_line_cfg;
        src_offset  = 16'd0;
        tok_begin   = 16'd0;
        tok_len     = 16'd0;
        point_seen  = 1'b0;
        word_window = 40'd0;
    endfunction

    // byte seen from the idle mode; returns 1 when the file ended
    function automatic bit fresh_byte(input logic [7:0] c, input logic [15:0] here);
        lex_mode = csl_pkg::MODE_IDLE;
        if (c == csl_pkg::CH_SPACE) begin
            return 1'b0;
        end else if (c == csl_pkg::CH_NL) begin
            line_cnt = bump(line_cnt);
        end else if (alpha_c(c)) begin
            lex_mode    = csl_pkg::MODE_IDENT;
            tok_begin   = here;
            tok_len     = 16'd1;
            word_window = {32'd0, c};
        end else if (numeral_c(c)) begin
            lex_mode   = csl_pkg::MODE_NUMBER;
            tok_begin  = here;
            tok_len    = 16'd1;
            point_seen = 1'b0;
        end else if (c == csl_pkg::CH_QUOTE) begin
            lex_mode  = csl_pkg::MODE_STRING;
            tok_begin = bump(here);
            tok_len   = 16'd0;
        end else if (c == csl_pkg::CH_NUL) begin
            emit(csl_pkg::KIND_EOF, 8'd0, here, 16'd0);
            restart_scan();
            return 1'b1;
        end else if (op_index(c) < 8) begin
            lex_mode  = csl_pkg::MODE_OPWAIT;
            held_op   = c;
            tok_begin = here;
        end else if (c == csl_pkg::CH_SLASH) begin
            lex_mode  = csl_pkg::MODE_SLASH;
            tok_begin = here;
        end else begin
            emit(csl_pkg::KIND_CHAR, c, here, 16'd1);
        end
        return 1'b0;
    endfunction

    // advance the scanner by one accepted byte and queue the tokens it completes
    function automatic void lex_byte(input logic [7:0] c);
        logic [15:0] here;
        bit          again;
        bit          restarted;
        int          slot;
        here      = src_offset;
        again     = 1'b0;
        restarted = 1'b0;
        step_tokens.delete();
        case (lex_mode)
            csl_pkg::MODE_IDENT: begin
                if (alpha_c(c) || numeral_c(c)) begin
                    if (tok_len < 16'd5) begin
                        word_window[8*tok_len +: 8] = c;
                    end
                    tok_len = bump(tok_len);
                end else begin
                    emit(word_kind(), 8'd0, tok_begin, tok_len);
                    again = 1'b1;
                end
            end
            csl_pkg::MODE_NUMBER: begin
                if (numeral_c(c) || c == csl_pkg::CH_POINT) begin
                    if (c == csl_pkg::CH_POINT) begin
                        point_seen = 1'b1;
                    end
                    tok_len = bump(tok_len);
                end else begin
                    emit(point_seen ? csl_pkg::KIND_DOUBLE : csl_pkg::KIND_INT, 8'd0,
                         tok_begin, tok_len);
                    again = 1'b1;
                end
            end
            csl_pkg::MODE_STRING: begin
                if (c == csl_pkg::CH_QUOTE) begin
                    emit(csl_pkg::KIND_STRING, 8'd0, tok_begin, tok_len);
                    lex_mode = csl_pkg::MODE_IDLE;
                end else if (c == csl_pkg::CH_NUL) begin
                    emit(csl_pkg::KIND_UNTERM, 8'd0, tok_begin, tok_len);
                    again = 1'b1;
                end else begin
                    if (c == csl_pkg::CH_NL) begin
                        line_cnt = bump(line_cnt);
                    end
                    tok_len = bump(tok_len);
                end
            end
            csl_pkg::MODE_OPWAIT: begin
                slot = op_index(held_op);
                if (slot < 8 && op_tails[slot] == c) begin
                    emit(csl_pkg::KIND_OP0 + 5'(slot), 8'd0, tok_begin, 16'd2);
                    lex_mode = csl_pkg::MODE_IDLE;
                end else begin
                    emit(csl_pkg::KIND_CHAR, held_op, tok_begin, 16'd1);
                    again = 1'b1;
                end
            end
            csl_pkg::MODE_SLASH: begin
                if (c == csl_pkg::CH_SLASH) begin
                    lex_mode = csl_pkg::MODE_LINECOM;
                end else if (c == csl_pkg::CH_STAR) begin
                    lex_mode = csl_pkg::MODE_BLOCK;
                end else begin
                    emit(csl_pkg::KIND_CHAR, csl_pkg::CH_SLASH, tok_begin, 16'd1);
                    again = 1'b1;
                end
            end
            csl_pkg::MODE_LINECOM: begin
                if (c == csl_pkg::CH_NL) begin
                    line_cnt = bump(line_cnt);
                    lex_mode = csl_pkg::MODE_IDLE;
                end else if (c == csl_pkg::CH_NUL) begin
                    again = 1'b1;
                end
            end
            csl_pkg::MODE_BLOCK, csl_pkg::MODE_BLOCKSTAR: begin
                if (c == csl_pkg::CH_NUL) begin
                    again = 1'b1;
                end else if (c == csl_pkg::CH_NL) begin
                    line_cnt = bump(line_cnt);
                    lex_mode = csl_pkg::MODE_BLOCK;
                end else if (c == csl_pkg::CH_STAR) begin
                    lex_mode = csl_pkg::MODE_BLOCKSTAR;
                end else if (c == csl_pkg::CH_SLASH && lex_mode == csl_pkg::MODE_BLOCKSTAR) begin
                    lex_mode = csl_pkg::MODE_IDLE;
                end else begin
                    lex_mode = csl_pkg::MODE_BLOCK;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase
        if (again) begin
            restarted = fresh_byte(c, here);
        end
        if (!restarted) begin
            src_offset = bump(src_offset);
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
        end
    endfunction

    // receiver stall pattern: changes style when its random run length runs out
    int ready_style = 0;
    int style_left = 0;
    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(8, 80);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= style_left[2];
        endcase
    end

    // result check, sampled on the falling edge before the transfer edge
    always @(negedge aclk) begin
        token_t seen;
        token_t want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            seen.kind  = m_axis_tdata[4:0];
            seen.code  = m_axis_tdata[12:5];
            seen.line  = m_axis_tdata[28:13];
            seen.start = m_axis_tdata[44:29];
            seen.len   = m_axis_tdata[60:45];
            seen.last  = m_axis_tlast;
            if (pending_tokens.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected token: kind %0d code %h line %0d start %0d len %0d",
                             seen.kind, seen.code, seen.line, seen.start, seen.len);
                end
            end else begin
                want = pending_tokens.pop_front();
                if (seen.kind !== want.kind || seen.code !== want.code ||
                    seen.line !== want.line || seen.start !== want.start ||
                    seen.len !== want.len || seen.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("token mismatch at %0t: expected kind %0d code %h line %0d",
                                 $realtime, want.kind, want.code, want.line);
                        $display("  start %0d len %0d last %0d; got kind %0d code %h",
                                 want.start, want.len, want.last, seen.kind, seen.code);
                        $display("  line %0d start %0d len %0d last %0d",
                                 seen.line, seen.start, seen.len, seen.last);
                    end
                end
            end
        end
    end

    // one source byte transfer, then maybe a gap between bursts
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        int gap;
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_axis_tready;
            @(posedge aclk);
        end
        lex_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_tokens.size() != 0);
    endtask

    task automatic set_first_line(input logic [15:0] value);
        wait_for_results();
        repeat (4) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        first_line_cfg = value;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        script.insert(script.size(), b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            script.insert(script.size(), s[i]);
        end
    endfunction

    task automatic send_script();
        foreach (script[i]) begin
            send_byte(script[i]);
        end
        script.delete();
    endtask

    // any byte but the quote and zero, newlines now and then
    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == csl_pkg::CH_QUOTE) begin
            b = csl_pkg::CH_NL;
        end
        return b;
    endfunction

    function automatic void add_random_lexeme();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            // keyword, sometimes stretched into an ident
            add_text(keyword_list[$urandom_range(0, 6)]);
            if ($urandom_range(0, 3) == 0) begin
                add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
            end
        end else if (pick < 28) begin
            n = $urandom_range(1, 8);
            add_byte(word_chars[$urandom_range(0, 52)]);
            repeat (n - 1) add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
        end else if (pick < 38) begin
            n = $urandom_range(1, 6);
            add_byte(8'(8'h30 + $urandom_range(0, 9)));
            repeat (n - 1) begin
                add_byte(($urandom_range(0, 4) == 0) ? csl_pkg::CH_POINT :
                         8'(8'h30 + $urandom_range(0, 9)));
            end
        end else if (pick < 46) begin
            add_byte(csl_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) add_byte(string_byte());
            add_byte(csl_pkg::CH_QUOTE);
        end else if (pick < 58) begin
            // operator pair or its first character alone
            n = $urandom_range(0, 7);
            add_byte(op_heads[n]);
            if ($urandom_range(0, 2) != 0) begin
                add_byte(op_tails[n]);
            end
        end else if (pick < 64) begin
            add_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        end else if (pick < 70) begin
            add_text("//");
            repeat ($urandom_range(0, 8)) begin
                n = $urandom_range(1, 255);
                add_byte((n == csl_pkg::CH_NL) ? csl_pkg::CH_SPACE : 8'(n));
            end
            add_byte(csl_pkg::CH_NL);
        end else if (pick < 76) begin
            add_text("/*");
            repeat ($urandom_range(0, 8)) begin
                add_byte(($urandom_range(0, 3) == 0) ? csl_pkg::CH_STAR
                                                      : 8'($urandom_range(1, 255)));
            end
            // close with one or two stars
            if ($urandom_range(0, 1) == 0) begin
                add_byte(csl_pkg::CH_STAR);
            end
            add_text("*/");
        end else begin
            // noise
            add_byte(8'($urandom_range(1, 255)));
        end
        // separator, or none so that tokens abut
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            add_byte(csl_pkg::CH_SPACE);
        end else if (pick < 12) begin
            add_byte(csl_pkg::CH_NL);
        end
    endfunction

    // a source file of random tokens, sometimes cut off in a string or comment
    task automatic random_program(input int target);
        int tail;
        while (script.size() < target) begin
            add_random_lexeme();
        end
        tail = $urandom_range(0, 9);
        if (tail == 0) begin
            add_byte(csl_pkg::CH_QUOTE);
            add_text("open\n");
        end else if (tail == 1) begin
            add_text("/* open");
        end else if (tail == 2) begin
            add_text("// open");
        end
        add_byte(csl_pkg::CH_NUL);
        send_script();
    endtask

    task automatic test_special_cases();
        // every keyword, newline after a token, every operator pair
        add_text("if\nelse while\ndo for break\nint;>=<===!=&&||++--\n");
        // ident cut by an operator, unpaired operator, double, int
        add_text("ab=c 1.2. 9 ");
        // string across a line, both comment styles, lone slash
        add_byte(csl_pkg::CH_QUOTE);
        add_text("q\n");
        add_byte(csl_pkg::CH_QUOTE);
        add_text("//z\n/*a**/ /x");
        // control and high bytes as single characters
        add_byte(8'hff);
        add_byte(8'h01);
        add_text("!x<<");
        // unterminated string gives two results on the zero byte
        add_byte(csl_pkg::CH_QUOTE);
        add_text("u");
        add_byte(csl_pkg::CH_NUL);
        // end inside comments, and a token closed by the end
        add_text("/*\n");
        add_byte(csl_pkg::CH_NUL);
        add_text("// x");
        add_byte(csl_pkg::CH_NUL);
        add_text("y");
        add_byte(csl_pkg::CH_NUL);
        send_script();
    endtask

    task automatic test_sender_pause();
        add_text("x = 1;");
        send_script();
        wait_for_results();
        add_text("y\n");
        add_byte(csl_pkg::CH_NUL);
        send_script();
    endtask

    task automatic test_line_limits();
        set_first_line(16'hffff);
        add_text("a\n");
        add_byte(csl_pkg::CH_NUL);
        add_text("b\n\nc");
        add_byte(csl_pkg::CH_NUL);
        send_script();
        set_first_line(16'h0000);
        add_byte(csl_pkg::CH_NUL);
        add_text("d\ne");
        add_byte(csl_pkg::CH_NUL);
        send_script();
        set_first_line(16'($urandom));
        add_byte(csl_pkg::CH_NUL);
        add_text("f\n\"g\nh\"");
        add_byte(csl_pkg::CH_NUL);
        send_script();
    endtask

    task automatic test_random_programs();
        logic [15:0] line_starts [4];
        int          start_count;
        line_starts[0] = 16'($urandom);
        line_starts[1] = 16'hfffe;
        line_starts[2] = 16'h0000;
        line_starts[3] = 16'd1;
        for (int p = 0; p < 4; p++) begin
            set_first_line(line_starts[p]);
            // a zero byte so that the new line start is loaded
            add_byte(csl_pkg::CH_NUL);
            send_script();
            start_count = bytes_sent;
            while (bytes_sent - start_count < 110) begin
                random_program($urandom_range(8, 60));
            end
        end
    endtask

    initial begin
        first_line_cfg = 16'd1;
        restart_scan();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_sender_pause();
        test_line_limits();
        test_random_programs();
        wait_for_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && pending_tokens.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
